/* rtl/cpfa_pkg.sv */
package cpfa_pkg;

   localparam int MAX_FRAMES = 1024;
   localparam int ADDR_W     = $clog2(MAX_FRAMES);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int WORD_W     = CNT_W + 2;

   localparam logic [1:0] FS_FREE  = 2'd0;
   localparam logic [1:0] FS_FIXED = 2'd1;
   localparam logic [1:0] FS_DIRTY = 2'd2;

   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_FREE  = 2'd2;
   localparam logic [1:0] MODE_FREE1 = 2'd3;

   localparam logic REG_RESERVED = 1'b0;
   localparam logic REG_TOTAL    = 1'b1;

   localparam logic [CNT_W-1:0] RESERVED_RESET = CNT_W'(64);
   localparam logic [CNT_W-1:0] TOTAL_RESET    = CNT_W'(MAX_FRAMES);

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] first_frame;
      logic [CNT_W-1:0]  free_frames;
      logic [CNT_W-1:0]  used_frames;
   } result_type;

endpackage

/* rtl/contiguous_page_frame_allocator_top.sv */
// Operation: init writes the whole frame map, then recounts it; other transactions
// may read and write the frame map before a recount sweep of the free frames.
// Throughput: one transaction at a time, set by the single map RAM port pair.
// Reset: synchronous; map is unready and the free count zero until init.
// The map RAM is not cleared; init writes every entry.
module contiguous_page_frame_allocator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_mode,
   input  logic [cpfa_pkg::CNT_W-1:0]       req_request_pages,
   input  logic                             req_user_page,
   input  logic [cpfa_pkg::ADDR_W-1:0]      req_frame_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_ok,
   output logic [cpfa_pkg::ADDR_W-1:0]      rsp_first_frame,
   output logic [cpfa_pkg::CNT_W-1:0]       rsp_free_frames,
   output logic [cpfa_pkg::CNT_W-1:0]       rsp_used_frames,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [cpfa_pkg::CNT_W-1:0]       csr_wdata
);

   logic [cpfa_pkg::CNT_W-1:0] rsv_ff, total_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   cpfa_pkg::result_type       rsp_ff, res;
   logic                       idle, res_valid, out_free;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && rsp_stall);

   cpfa_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_mode          (req_mode),
      .req_request_pages (req_request_pages),
      .req_user_page     (req_user_page),
      .req_frame_index   (req_frame_index),
      .reserved_pages    (rsv_ff),
      .page_total        (total_ff),
      .out_free          (out_free),
      .idle              (idle),
      .res_valid         (res_valid),
      .res               (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsv_ff       <= cpfa_pkg::RESERVED_RESET;
         total_ff     <= cpfa_pkg::TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               cpfa_pkg::REG_RESERVED: rsv_ff   <= csr_wdata;
               cpfa_pkg::REG_TOTAL:    total_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign csr_ready       = 1'b1;
   assign req_stall       = !idle;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ff.ok;
   assign rsp_first_frame = rsp_ff.first_frame;
   assign rsp_free_frames = rsp_ff.free_frames;
   assign rsp_used_frames = rsp_ff.used_frames;

endmodule

/* rtl/cpfa_ram.sv */
module cpfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cpfa_ctrl.sv */
module cpfa_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [1:0]                       req_mode,
   input  logic [cpfa_pkg::CNT_W-1:0]       req_request_pages,
   input  logic                             req_user_page,
   input  logic [cpfa_pkg::ADDR_W-1:0]      req_frame_index,
   input  logic [cpfa_pkg::CNT_W-1:0]       reserved_pages,
   input  logic [cpfa_pkg::CNT_W-1:0]       page_total,
   input  logic                             out_free,
   output logic                             idle,
   output logic                             res_valid,
   output cpfa_pkg::result_type             res
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_SCAN, ST_AWRITE, ST_RD, ST_CHK, ST_FWALK, ST_COUNT, ST_DONE
   } state_type;

   localparam int AW = cpfa_pkg::ADDR_W;
   localparam int CW = cpfa_pkg::CNT_W;

   state_type state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] req_ff, req_in;
   logic          user_ff, user_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] rsv_ff, rsv_in;
   logic          ready_ff, ready_in;
   logic          ok_ff, ok_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic          dv_ff, dv_in;
   logic [CW-1:0] daddr_ff, daddr_in;
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] fc_ff, fc_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [cpfa_pkg::WORD_W-1:0] wr_data;
   logic [AW-1:0]             rd_addr;
   logic [cpfa_pkg::WORD_W-1:0] rd_data;
   logic [1:0]                rd_state;
   logic [CW-1:0]             rd_run;
   logic [CW-1:0]             total_now;
   logic [CW-1:0]             head_calc;

   cpfa_ram #(.WIDTH(cpfa_pkg::WORD_W), .DEPTH(cpfa_pkg::MAX_FRAMES)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_state  = rd_data[1:0];
   assign rd_run    = rd_data[cpfa_pkg::WORD_W-1:2];
   assign total_now = (page_total > cpfa_pkg::TOTAL_RESET) ? cpfa_pkg::TOTAL_RESET : page_total;
   assign head_calc = daddr_ff - req_ff + CW'(1);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      req_in   = req_ff;
      user_in  = user_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      rsv_in   = rsv_ff;
      ready_in = ready_ff;
      ok_in    = ok_ff;
      head_in  = head_ff;
      addr_in  = addr_ff;
      dv_in    = 1'b0;
      daddr_in = addr_ff;
      run_in   = run_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      fc_in    = fc_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_ff[AW-1:0];
      wr_data  = {CW'(0), cpfa_pkg::FS_FREE};
      rd_addr  = addr_ff[AW-1:0];
      res_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               req_in   = req_request_pages;
               user_in  = req_user_page;
               idx_in   = req_frame_index;
               total_in = total_now;
               rsv_in   = reserved_pages;
               ok_in    = 1'b0;
               head_in  = '0;
               addr_in  = '0;
               if (req_mode == cpfa_pkg::MODE_INIT) begin
                  state_in = ST_INIT;
               end else if (!ready_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_COUNT;
                  cnt_in   = '0;
                  unique case (req_mode)
                     cpfa_pkg::MODE_ALLOC: begin
                        if (req_request_pages != '0 &&
                            ({1'b0, reserved_pages} + {1'b0, req_request_pages}) <
                            {1'b0, total_now}) begin
                           state_in = ST_SCAN;
                           addr_in  = reserved_pages;
                           run_in   = '0;
                        end
                     end
                     cpfa_pkg::MODE_FREE: begin
                        if (CW'(req_frame_index) < total_now) begin
                           ok_in = 1'b1;
                           if (CW'(req_frame_index) < reserved_pages) begin
                              state_in = ST_FWALK;
                              addr_in  = CW'(req_frame_index);
                              len_in   = CW'(1);
                           end else begin
                              state_in = ST_RD;
                           end
                        end
                     end
                     cpfa_pkg::MODE_FREE1: begin
                        if (CW'(req_frame_index) < total_now &&
                            CW'(req_frame_index) >= reserved_pages) begin
                           state_in = ST_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = {CW'(0), (addr_ff < rsv_ff) ? cpfa_pkg::FS_FIXED : cpfa_pkg::FS_FREE};
            addr_in = addr_ff + CW'(1);
            if (addr_ff == CW'(cpfa_pkg::MAX_FRAMES - 1)) begin
               ready_in = 1'b1;
               ok_in    = 1'b1;
               state_in = ST_COUNT;
               addr_in  = '0;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (addr_ff < total_ff) begin
               dv_in   = 1'b1;
               addr_in = addr_ff + CW'(1);
            end
            if (dv_ff) begin
               if (rd_state == cpfa_pkg::FS_FREE) begin
                  run_in = run_ff + CW'(1);
                  if (run_ff + CW'(1) == req_ff) begin
                     head_in  = head_calc[AW-1:0];
                     addr_in  = head_calc;
                     len_in   = req_ff;
                     dv_in    = 1'b0;
                     state_in = ST_AWRITE;
                  end
               end else begin
                  run_in = '0;
               end
            end else if (addr_ff >= total_ff) begin
               state_in = ST_COUNT;
               addr_in  = '0;
               cnt_in   = '0;
            end
         end
         ST_AWRITE: begin
            wr_en   = 1'b1;
            wr_data = {(addr_ff[AW-1:0] == head_ff) ? req_ff : CW'(0),
                       user_ff ? cpfa_pkg::FS_DIRTY : cpfa_pkg::FS_FIXED};
            addr_in = addr_ff + CW'(1);
            len_in  = len_ff - CW'(1);
            if (len_ff == CW'(1)) begin
               ok_in    = 1'b1;
               state_in = ST_COUNT;
               addr_in  = '0;
               cnt_in   = '0;
            end
         end
         ST_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (mode_ff == cpfa_pkg::MODE_FREE) begin
               if (rd_run == '0) begin
                  state_in = ST_COUNT;
                  addr_in  = '0;
               end else begin
                  state_in = ST_FWALK;
                  addr_in  = CW'(idx_ff);
                  len_in   = rd_run;
               end
            end else begin
               if (rd_state == cpfa_pkg::FS_DIRTY) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff;
                  ok_in   = 1'b1;
               end
               state_in = ST_COUNT;
               addr_in  = '0;
            end
         end
         ST_FWALK: begin
            if (addr_ff < total_ff && len_ff != '0) begin
               wr_en   = 1'b1;
               addr_in = addr_ff + CW'(1);
               len_in  = len_ff - CW'(1);
            end else begin
               state_in = ST_COUNT;
               addr_in  = '0;
            end
         end
         ST_COUNT: begin
            if (addr_ff < total_ff) begin
               dv_in   = 1'b1;
               addr_in = addr_ff + CW'(1);
            end
            if (dv_ff) begin
               if (rd_state == cpfa_pkg::FS_FREE) begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end else if (addr_ff >= total_ff) begin
               fc_in    = cnt_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         fc_ff    <= '0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         fc_ff    <= fc_in;
         dv_ff    <= dv_in;
      end
      mode_ff  <= mode_in;
      req_ff   <= req_in;
      user_ff  <= user_in;
      idx_ff   <= idx_in;
      total_ff <= total_in;
      rsv_ff   <= rsv_in;
      ok_ff    <= ok_in;
      head_ff  <= head_in;
      addr_ff  <= addr_in;
      daddr_ff <= daddr_in;
      run_ff   <= run_in;
      len_ff   <= len_in;
      cnt_ff   <= cnt_in;
   end

   assign idle            = (state_ff == ST_IDLE);
   assign res.ok          = ok_ff;
   assign res.first_frame = head_ff;
   assign res.free_frames = fc_ff;
   assign res.used_frames = total_ff - fc_ff;

endmodule

/* rtl/cpfa_checker.sv */
module cpfa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_ok,
   input logic [cpfa_pkg::ADDR_W-1:0] rsp_first_frame,
   input logic [cpfa_pkg::CNT_W-1:0]  rsp_free_frames,
   input logic [cpfa_pkg::CNT_W-1:0]  rsp_used_frames
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_free_frames))
      else $error("stalled response changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a second transaction while busy");

   a_fail_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_first_frame == '0)
      else $error("failed transaction carries a head frame");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_free_frames} + {1'b0, rsp_used_frames}) <=
                    (cpfa_pkg::CNT_W + 1)'(cpfa_pkg::MAX_FRAMES))
      else $error("free plus used frames exceeds the map");

endmodule

bind contiguous_page_frame_allocator_top cpfa_checker u_cpfa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_ok          (rsp_ok),
   .rsp_first_frame (rsp_first_frame),
   .rsp_free_frames (rsp_free_frames),
   .rsp_used_frames (rsp_used_frames)
);
